@@ src/blue_aqm_pkg.sv @@
// shared types, codes and constants of the blue queue-management decision block
package blue_aqm_pkg;

	// operating modes of an input item
	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	// verdict codes
	localparam logic [1:0] VERDICT_ENQ    = 2'd0;
	localparam logic [1:0] VERDICT_EARLY  = 2'd1;
	localparam logic [1:0] VERDICT_FORCED = 2'd2;
	localparam logic [1:0] VERDICT_DEQ    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_MARK_PROB = 2'd0;
	localparam logic [1:0] CFG_HOLD_TIME_US  = 2'd1;
	localparam logic [1:0] CFG_ECN_ENABLE    = 2'd2;
	localparam logic [1:0] CFG_QUEUE_LIMIT   = 2'd3;

	// configuration reset values
	localparam logic [15:0] MAX_MARK_PROB_RST = 16'd1000;
	localparam logic [31:0] HOLD_TIME_US_RST  = 32'd50000;
	localparam logic        ECN_ENABLE_RST    = 1'b0;
	localparam logic [15:0] QUEUE_LIMIT_RST   = 16'd200;

	// decision constants
	localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
	localparam logic [15:0] PROB_RESTART = 16'd1;
	localparam int unsigned RAISE_SHIFT  = 3;

	// remainder unit: four dividend bits per cycle over a 32-bit padded dividend
	localparam int unsigned REM_BITS_PER_STEP = 4;
	localparam int unsigned DIV_STEPS         = 8;
	localparam int unsigned DIV_STEP_W        = $clog2(DIV_STEPS);

	typedef struct packed {
		logic        mode;
		logic [31:0] now_sec;
		logic [19:0] now_usec;
		logic [15:0] queue_length;
		logic [30:0] random_value;
		logic        ecn_markable;
		logic        dequeue_empty;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic        ecn_marked;
		logic [15:0] mark_probability;
		logic [31:0] marked_total;
		logic [31:0] early_drop_total;
		logic [31:0] forced_drop_total;
		logic        is_idle;
	} out_item_t;

	typedef struct packed {
		logic [15:0] max_mark_prob;
		logic [31:0] hold_time_us;
		logic        ecn_enable;
		logic [15:0] queue_limit;
	} cfg_t;

	// classified item passed from front to back
	typedef struct packed {
		in_item_t    item;
		logic [15:0] rnd_rem;
	} work_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

@@ src/blue_aqm_drop_decision_top.sv @@
// top level of the blue queue-management drop/mark decision block
//
//   channel   handshake              payload
//   in        in_valid / in_stall    in_data  (in_item_t)
//   out       out_valid / out_stall  out_data (out_item_t)
//   cfg       cfg_we                 cfg_index, cfg_data
//
// the front accepts an item when idle, then the remainder unit retires four
// bits of random_value per cycle; no new item is taken until it is queued.
// the back is quicker, so the remainder unit sets the rate if out_stall is low.
// reset loads the configuration defaults and clears probability and counters.
// a stalled output holds its result while the back and queue keep working.
module blue_aqm_drop_decision_top import blue_aqm_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t         cfg_q;
	logic         push;
	work_item_t   push_data;
	logic         pop;
	work_item_t   pop_data;
	fifo_status_t fifo_st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_mark_prob <= MAX_MARK_PROB_RST;
			cfg_q.hold_time_us  <= HOLD_TIME_US_RST;
			cfg_q.ecn_enable    <= ECN_ENABLE_RST;
			cfg_q.queue_limit   <= QUEUE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_MARK_PROB: cfg_q.max_mark_prob <= cfg_data[15:0];
				CFG_HOLD_TIME_US:  cfg_q.hold_time_us  <= cfg_data;
				CFG_ECN_ENABLE:    cfg_q.ecn_enable    <= cfg_data[0];
				CFG_QUEUE_LIMIT:   cfg_q.queue_limit   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// classify
	blue_aqm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.max_mark_prob (cfg_q.max_mark_prob),
		.push          (push),
		.push_data     (push_data),
		.fifo_st       (fifo_st)
	);

	// decouple
	blue_aqm_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (fifo_st)
	);

	// decide
	blue_aqm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fifo_st   (fifo_st),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// every enqueue leaves the block busy
	a_enq_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.verdict != VERDICT_DEQ) |-> !out_data.is_idle)
		else $error("enqueue result reports idle");

	// an early drop is never also ecn marked
	a_early_unmarked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.verdict == VERDICT_EARLY) |-> !out_data.ecn_marked)
		else $error("early drop carries ecn mark");

	// the front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_st.full)
		else $error("push into full queue");
`endif

endmodule

@@ src/blue_aqm_front.sv @@
// front end: accepts items and works out random_value modulo max_mark_prob
module blue_aqm_front import blue_aqm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  in_item_t     in_data,
	input  logic [15:0]  max_mark_prob,
	output logic         push,
	output work_item_t   push_data,
	input  fifo_status_t fifo_st
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_HOLD
	} front_state_t;

	front_state_t          state_q;
	in_item_t              item_q;
	logic [31:0]           div_q;
	logic [15:0]           rem_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [15:0]           rem_next;
	logic                  last_step;

	// four restoring remainder steps per cycle
	always_comb begin
		logic [16:0] t;
		logic [15:0] r;
		r = rem_q;
		for (int i = 0; i < REM_BITS_PER_STEP; i++) begin
			t = {r, div_q[31-i]};
			if (t >= {1'b0, max_mark_prob}) begin
				r = 16'(t - {1'b0, max_mark_prob});
			end else begin
				r = t[15:0];
			end
		end
		rem_next = r;
	end

	assign last_step = (step_q == DIV_STEP_W'(DIV_STEPS - 1));
	assign in_stall  = (state_q != F_IDLE);

	// hand the classified item to the queue
	assign push = ((state_q == F_DIV) && last_step && !fifo_st.full) ||
	              ((state_q == F_HOLD) && !fifo_st.full);
	assign push_data.item    = item_q;
	assign push_data.rnd_rem = (state_q == F_HOLD) ? rem_q : rem_next;

	// sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			item_q  <= '0;
			div_q   <= '0;
			rem_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						div_q   <= {1'b0, in_data.random_value};
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q  <= rem_next;
					div_q  <= div_q << REM_BITS_PER_STEP;
					step_q <= step_q + DIV_STEP_W'(1);
					if (last_step) begin
						state_q <= fifo_st.full ? F_HOLD : F_IDLE;
					end
				end
				F_HOLD: begin
					if (!fifo_st.full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/blue_aqm_fifo.sv @@
// short queue of classified items between front and back
module blue_aqm_fifo import blue_aqm_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  work_item_t   push_data,
	input  logic         pop,
	output work_item_t   pop_data,
	output fifo_status_t status
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	work_item_t    entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ src/blue_aqm_back.sv @@
// back end: dequeue idle tracking, idle decay, early/forced decision, probability raise and counters
module blue_aqm_back import blue_aqm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  fifo_status_t fifo_st,
	input  work_item_t   pop_data,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output out_item_t    out_data
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DECAY,
		B_DECIDE,
		B_MUL2,
		B_RAISE,
		B_DONE
	} back_state_t;

	back_state_t state_q;
	work_item_t  cur_q;
	logic [31:0] prod_q;
	logic [1:0]  verdict_q;
	logic        marked_q;
	logic [15:0] mark_prob_q;
	logic        idle_q;
	logic [31:0] last_sec_q;
	logic [19:0] last_usec_q;
	logic [31:0] marked_cnt_q;
	logic [31:0] early_cnt_q;
	logic [31:0] forced_cnt_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [31:0] dsec;
	logic [31:0] prod;
	logic [31:0] elapsed;
	logic        over_hold;
	logic        early_hit;
	logic        mark_now;
	logic        drop_early;
	logic        forced;
	logic [16:0] raised;
	logic [15:0] raised_clamped;
	logic        out_free;

	// elapsed time since the last update, wrapping 32-bit arithmetic
	assign dsec      = cur_q.item.now_sec - last_sec_q;
	assign prod      = dsec * USEC_PER_SEC;
	assign elapsed   = prod_q + ({12'b0, cur_q.item.now_usec} - {12'b0, last_usec_q});
	assign over_hold = (elapsed > cfg.hold_time_us);

	// early test and verdict classes
	always_comb begin
		early_hit  = (cfg.max_mark_prob != '0) && (cur_q.rnd_rem < mark_prob_q) &&
		             (cur_q.item.queue_length > 16'd1);
		mark_now   = early_hit && cfg.ecn_enable && cur_q.item.ecn_markable;
		drop_early = early_hit && !mark_now;
		forced     = !drop_early && (cur_q.item.queue_length >= cfg.queue_limit);
	end

	// forced-drop raise, clamped to the maximum
	assign raised         = {1'b0, mark_prob_q} + 17'(cfg.max_mark_prob >> RAISE_SHIFT);
	assign raised_clamped = (raised > {1'b0, cfg.max_mark_prob}) ? cfg.max_mark_prob
	                                                              : raised[15:0];

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == B_IDLE) && !fifo_st.empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer, decision state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			cur_q        <= '0;
			prod_q       <= '0;
			verdict_q    <= VERDICT_ENQ;
			marked_q     <= 1'b0;
			mark_prob_q  <= '0;
			idle_q       <= 1'b1;
			last_sec_q   <= '0;
			last_usec_q  <= '0;
			marked_cnt_q <= '0;
			early_cnt_q  <= '0;
			forced_cnt_q <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != B_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!fifo_st.empty) begin
						cur_q   <= pop_data;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					prod_q   <= prod;
					marked_q <= 1'b0;
					if (cur_q.item.mode == MODE_DEQ) begin
						verdict_q <= VERDICT_DEQ;
						if (cur_q.item.dequeue_empty) begin
							if (!idle_q) begin
								idle_q      <= 1'b1;
								last_sec_q  <= cur_q.item.now_sec;
								last_usec_q <= cur_q.item.now_usec;
							end
						end else begin
							idle_q <= 1'b0;
						end
						state_q <= B_DONE;
					end else begin
						verdict_q <= VERDICT_ENQ;
						state_q   <= idle_q ? B_DECAY : B_DECIDE;
					end
				end
				B_DECAY: begin
					idle_q <= 1'b0;
					if (dsec > 32'd1) begin
						mark_prob_q <= PROB_RESTART;
						last_sec_q  <= cur_q.item.now_sec;
						last_usec_q <= cur_q.item.now_usec;
					end else if (over_hold) begin
						if (mark_prob_q != '0) begin
							mark_prob_q <= mark_prob_q - 16'd1;
						end
						last_sec_q  <= cur_q.item.now_sec;
						last_usec_q <= cur_q.item.now_usec;
					end
					state_q <= B_DECIDE;
				end
				B_DECIDE: begin
					if (mark_now) begin
						marked_q     <= 1'b1;
						marked_cnt_q <= marked_cnt_q + 32'd1;
					end
					if (drop_early) begin
						verdict_q   <= VERDICT_EARLY;
						early_cnt_q <= early_cnt_q + 32'd1;
						state_q     <= B_DONE;
					end else if (forced) begin
						verdict_q    <= VERDICT_FORCED;
						forced_cnt_q <= forced_cnt_q + 32'd1;
						state_q      <= B_MUL2;
					end else begin
						state_q <= B_DONE;
					end
				end
				B_MUL2: begin
					prod_q  <= prod;
					state_q <= B_RAISE;
				end
				B_RAISE: begin
					if (over_hold) begin
						mark_prob_q <= raised_clamped;
						last_sec_q  <= cur_q.item.now_sec;
						last_usec_q <= cur_q.item.now_usec;
					end
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_free) begin
						out_q.verdict           <= verdict_q;
						out_q.ecn_marked        <= marked_q;
						out_q.mark_probability  <= mark_prob_q;
						out_q.marked_total      <= marked_cnt_q;
						out_q.early_drop_total  <= early_cnt_q;
						out_q.forced_drop_total <= forced_cnt_q;
						out_q.is_idle           <= idle_q;
						out_valid_q             <= 1'b1;
						state_q                 <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/blue_aqm_drop_decision_top_tb.sv @@
// self-checking testbench of the blue queue-management drop/mark decision block
`timescale 1ns / 1ps

module blue_aqm_drop_decision_top_tb;
	import blue_aqm_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 45;
	localparam int BURST_ITEMS     = 24;
	localparam int RX_HOLD_CYCLES  = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// register copies seen by the predictor
	logic [15:0] c_max_prob;
	logic [31:0] c_hold_us;
	logic        c_ecn;
	logic [15:0] c_limit;

	// predicted block state
	logic [15:0] p_prob;
	logic        p_idle;
	logic [31:0] p_last_sec;
	logic [19:0] p_last_usec;
	logic [31:0] p_marked;
	logic [31:0] p_early;
	logic [31:0] p_forced;

	// traffic clock used by the random items
	logic [31:0] t_sec;
	logic [19:0] t_usec;

	out_item_t pending_decisions[$];

	bit quiet;
	int rx_hold_cycles;
	int cycle_count;
	int error_count;
	int report_count;
	int results_seen;
	int items_sent;
	int settings_used;
	int tally_enq;
	int tally_early;
	int tally_forced;
	int tally_deq;
	int tally_marks;

	blue_aqm_drop_decision_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited", cycle_count,
				pending_decisions.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic string fmt_result(out_item_t r);
		return $sformatf("verdict=%0d ecn=%0b prob=%0d marked=%0d early=%0d forced=%0d idle=%0b",
			r.verdict, r.ecn_marked, r.mark_probability, r.marked_total,
			r.early_drop_total, r.forced_drop_total, r.is_idle);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 55)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 40));
	endfunction

	task automatic model_reset();
		c_max_prob  = MAX_MARK_PROB_RST;
		c_hold_us   = HOLD_TIME_US_RST;
		c_ecn       = ECN_ENABLE_RST;
		c_limit     = QUEUE_LIMIT_RST;
		p_prob      = '0;
		p_idle      = 1'b1;
		p_last_sec  = '0;
		p_last_usec = '0;
		p_marked    = '0;
		p_early     = '0;
		p_forced    = '0;
	endtask

	// wrapping microseconds since the last probability update
	function automatic logic [31:0] usec_since(logic [31:0] dsec, logic [19:0] usec);
		return dsec * USEC_PER_SEC + ({12'd0, usec} - {12'd0, p_last_usec});
	endfunction

	function automatic void record_update(logic [31:0] sec, logic [19:0] usec);
		p_last_sec  = sec;
		p_last_usec = usec;
	endfunction

	// blue decision for one item; queues the expected result
	function automatic void blue_decide(in_item_t it);
		out_item_t   res;
		logic [31:0] dsec;
		logic [31:0] raised;
		logic        early;
		res = '0;
		if (it.mode == MODE_DEQ) begin
			res.verdict = VERDICT_DEQ;
			if (it.dequeue_empty) begin
				if (!p_idle) begin
					p_idle = 1'b1;
					record_update(it.now_sec, it.now_usec);
				end
			end else begin
				p_idle = 1'b0;
			end
		end else begin
			res.verdict = VERDICT_ENQ;
			// decay after an idle spell
			if (p_idle) begin
				dsec   = it.now_sec - p_last_sec;
				p_idle = 1'b0;
				if (dsec > 32'd1) begin
					p_prob = PROB_RESTART;
					record_update(it.now_sec, it.now_usec);
				end else if (usec_since(dsec, it.now_usec) > c_hold_us) begin
					if (p_prob != 16'd0)
						p_prob = p_prob - 16'd1;
					record_update(it.now_sec, it.now_usec);
				end
			end
			// early mark or drop
			early = (c_max_prob != 16'd0) &&
				(({1'b0, it.random_value} % {16'd0, c_max_prob}) < {16'd0, p_prob});
			if (early && it.queue_length > 16'd1) begin
				if (c_ecn && it.ecn_markable) begin
					res.ecn_marked = 1'b1;
					p_marked++;
				end else begin
					res.verdict = VERDICT_EARLY;
				end
			end
			if (res.verdict == VERDICT_ENQ && it.queue_length >= c_limit)
				res.verdict = VERDICT_FORCED;
			// counters, and the raise after a forced drop
			if (res.verdict == VERDICT_EARLY) begin
				p_early++;
			end else if (res.verdict == VERDICT_FORCED) begin
				dsec = it.now_sec - p_last_sec;
				if (usec_since(dsec, it.now_usec) > c_hold_us) begin
					raised = {16'd0, p_prob} + {16'd0, c_max_prob >> RAISE_SHIFT};
					if (raised > {16'd0, c_max_prob})
						raised = {16'd0, c_max_prob};
					p_prob = raised[15:0];
					record_update(it.now_sec, it.now_usec);
				end
				p_forced++;
			end
		end
		res.mark_probability  = p_prob;
		res.marked_total      = p_marked;
		res.early_drop_total  = p_early;
		res.forced_drop_total = p_forced;
		res.is_idle           = p_idle;
		case (res.verdict)
			VERDICT_ENQ:    tally_enq++;
			VERDICT_EARLY:  tally_early++;
			VERDICT_FORCED: tally_forced++;
			default:        tally_deq++;
		endcase
		if (res.ecn_marked)
			tally_marks++;
		pending_decisions.push_back(res);
	endfunction

	// offer one item and hold it until accepted
	task automatic send_item(input in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		blue_decide(it);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_enq(input logic [31:0] sec, input logic [19:0] usec,
		input logic [15:0] qlen, input logic [30:0] rnd, input logic markable);
		in_item_t it;
		it              = '0;
		it.mode         = MODE_ENQ;
		it.now_sec      = sec;
		it.now_usec     = usec;
		it.queue_length = qlen;
		it.random_value = rnd;
		it.ecn_markable = markable;
		send_item(it);
	endtask

	task automatic send_deq(input logic [31:0] sec, input logic [19:0] usec, input logic empty);
		in_item_t it;
		it               = '0;
		it.mode          = MODE_DEQ;
		it.now_sec       = sec;
		it.now_usec      = usec;
		it.dequeue_empty = empty;
		send_item(it);
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_MAX_MARK_PROB: c_max_prob = val[15:0];
			CFG_HOLD_TIME_US:  c_hold_us  = val;
			CFG_ECN_ENABLE:    c_ecn      = val[0];
			CFG_QUEUE_LIMIT:   c_limit    = val[15:0];
			default:           ;
		endcase
	endtask

	// random traffic: a clock that mostly runs forward, queue lengths often near the limit
	function automatic in_item_t random_item();
		in_item_t it;
		int       r;
		int       u;
		int       lo;
		int       hi;
		r = int'($urandom_range(0, 99));
		if (r < 80) begin
			u = int'(t_usec) + int'($urandom_range(0, 120000));
			if (u >= 1000000) begin
				u     = u - 1000000;
				t_sec = t_sec + 32'd1;
			end
			t_usec = u[19:0];
		end else if (r < 92) begin
			t_sec = t_sec + $urandom_range(1, 3);
		end else if (r < 96) begin
			t_sec = $urandom();
		end else begin
			t_sec  = t_sec - $urandom_range(0, 2);
			t_usec = 20'($urandom_range(0, 999999));
		end
		it               = '0;
		it.mode          = ($urandom_range(0, 3) == 0) ? MODE_DEQ : MODE_ENQ;
		it.now_sec       = t_sec;
		it.now_usec      = t_usec;
		it.ecn_markable  = 1'($urandom_range(0, 1));
		it.dequeue_empty = 1'($urandom_range(0, 1));
		r = int'($urandom_range(0, 99));
		if (r < 15) begin
			it.queue_length = 16'($urandom_range(0, 3));
		end else if (r < 55) begin
			lo = int'(c_limit) - 2;
			hi = int'(c_limit) + 2;
			if (lo < 0)
				lo = 0;
			if (hi > 65535)
				hi = 65535;
			it.queue_length = 16'($urandom_range(lo, hi));
		end else if (r < 85) begin
			it.queue_length = 16'($urandom_range(0, c_limit));
		end else begin
			it.queue_length = 16'($urandom_range(0, 65535));
		end
		if ($urandom_range(0, 9) < 4)
			it.random_value = 31'($urandom_range(0, 2 * p_prob + 1));
		else
			it.random_value = 31'($urandom() >> 1);
		return it;
	endfunction

	// reset settings, limit boundary, forced raise and early drops
	task automatic test_reset_defaults();
		send_enq(32'd0, 20'd0, 16'd0, 31'd0, 1'b0);
		send_enq(32'd0, 20'd100000, QUEUE_LIMIT_RST, 31'd0, 1'b0);
		send_enq(32'd0, 20'd100001, 16'hFFFF, 31'h7FFF_FFFF, 1'b1);
		send_enq(32'd0, 20'd100002, 16'd2, 31'd0, 1'b1);
		send_enq(32'd0, 20'd100003, 16'd1, 31'd0, 1'b0);
		send_enq(32'd0, 20'd100004, QUEUE_LIMIT_RST - 16'd1, 31'd124, 1'b0);
		send_enq(32'd0, 20'd100005, QUEUE_LIMIT_RST - 16'd1, 31'd125, 1'b0);
	endtask

	// dequeue flavors and decay after idle spells
	task automatic test_idle_decay();
		send_deq(32'd0, 20'd300000, 1'b0);
		send_deq(32'd0, 20'd400000, 1'b1);
		send_deq(32'd0, 20'd450000, 1'b1);
		send_enq(32'd3, 20'd0, 16'd0, 31'd0, 1'b0);
		send_deq(32'd3, 20'd10, 1'b1);
		send_enq(32'd3, 20'd600000, 16'd0, 31'd0, 1'b0);
		send_deq(32'd3, 20'd700000, 1'b1);
		send_enq(32'd4, 20'd0, 16'd0, 31'd0, 1'b0);
	endtask

	// clock running backwards and wrapping
	task automatic test_clock_wrap();
		send_deq(32'd10, 20'd0, 1'b1);
		send_enq(32'd9, 20'd0, 16'd0, 31'd0, 1'b0);
		send_enq(32'd8, 20'd999999, QUEUE_LIMIT_RST, 31'd5, 1'b0);
		send_enq(32'hFFFF_FFFF, 20'd999999, 16'hFFFF, 31'd500, 1'b0);
		send_deq(32'd0, 20'd0, 1'b1);
		send_enq(32'd1, 20'd0, 16'd0, 31'd0, 1'b0);
	endtask

	// ecn marking, marked plus forced, probability above a lowered maximum
	task automatic test_ecn_marking();
		wait_drained();
		write_cfg(CFG_ECN_ENABLE, 32'd1);
		write_cfg(CFG_MAX_MARK_PROB, 32'd8);
		write_cfg(CFG_HOLD_TIME_US, 32'd1);
		write_cfg(CFG_QUEUE_LIMIT, 32'd4);
		settings_used++;
		send_enq(32'd1, 20'd500000, 16'd2, 31'd3, 1'b1);
		send_enq(32'd1, 20'd500010, 16'd5, 31'd7, 1'b1);
		send_enq(32'd1, 20'd500020, 16'd2, 31'd1, 1'b0);
		send_enq(32'd1, 20'd500030, 16'd0, 31'd0, 1'b1);
	endtask

	// long receiver hold-off while the sender keeps pushing, then a full drain
	task automatic test_backpressure();
		wait_drained();
		t_sec  = p_last_sec;
		t_usec = p_last_usec;
		quiet  = 1'b1;
		rx_hold_cycles = RX_HOLD_CYCLES;
		repeat (BURST_ITEMS) send_item(random_item());
		quiet = 1'b0;
		wait_drained();
	endtask

	task automatic set_phase_config(input int phase);
		logic [31:0] mx;
		logic [31:0] hold;
		logic [31:0] lim;
		logic        ecn;
		case (phase)
			0: begin
				mx = 32'd1; hold = 32'd1; ecn = 1'b1; lim = 32'd1;
			end
			1: begin
				mx = 32'hFFFF; hold = 32'hFFFF_FFFF; ecn = 1'b0; lim = 32'hFFFF;
			end
			2: begin
				mx = MAX_MARK_PROB_RST; hold = HOLD_TIME_US_RST;
				ecn = ECN_ENABLE_RST; lim = QUEUE_LIMIT_RST;
			end
			default: begin
				case ($urandom_range(0, 3))
					0:       mx = 32'd2;
					1:       mx = 32'd8;
					2:       mx = 32'd64;
					default: mx = $urandom_range(1, 65535);
				endcase
				hold = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 200000);
				ecn  = 1'($urandom_range(0, 1));
				lim  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 65535);
			end
		endcase
		write_cfg(CFG_MAX_MARK_PROB, mx);
		write_cfg(CFG_HOLD_TIME_US, hold);
		write_cfg(CFG_ECN_ENABLE, {31'd0, ecn});
		write_cfg(CFG_QUEUE_LIMIT, lim);
		settings_used++;
	endtask

	// random traffic under a series of register settings
	task automatic test_random_phases();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			set_phase_config(phase);
			quiet = (phase % 3 == 2);
			repeat (ITEMS_PER_PHASE) send_item(random_item());
		end
		quiet = 1'b0;
	endtask

	// receiver stalls: random, plus a long hold when a test asks for one
	initial begin : rx_stall_gen
		int left;
		left      = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				left           = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else if (left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				left = pick_gap();
			end
			if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare each accepted result with the oldest expected one
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_decisions.size() == 0) begin
				error_count++;
				if (report_count < 10) begin
					report_count++;
					$display("cycle %0d: result with none expected: %s", cycle_count,
						fmt_result(out_data));
				end
			end else begin
				want = pending_decisions.pop_front();
				if (out_data.verdict !== want.verdict || out_data.ecn_marked !== want.ecn_marked ||
					out_data.mark_probability !== want.mark_probability ||
					out_data.marked_total !== want.marked_total ||
					out_data.early_drop_total !== want.early_drop_total ||
					out_data.forced_drop_total !== want.forced_drop_total ||
					out_data.is_idle !== want.is_idle) begin
					error_count++;
					if (report_count < 10) begin
						report_count++;
						$display("cycle %0d: result %0d mismatch", cycle_count, results_seen);
						$display("  expected %s", fmt_result(want));
						$display("  actual   %s", fmt_result(out_data));
					end
				end
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		quiet          = 1'b0;
		rx_hold_cycles = 0;
		t_sec          = '0;
		t_usec         = '0;
		settings_used  = 1;
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_idle_decay();
		test_clock_wrap();
		test_ecn_marking();
		test_backpressure();
		test_random_phases();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d items (%0d dequeues) under %0d register settings, %0d cycles",
			items_sent, tally_deq, settings_used, cycle_count);
		$display("outcomes: %0d enqueued, %0d early drops, %0d forced drops, %0d ecn marks",
			tally_enq, tally_early, tally_forced, tally_marks);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
